// ----- src/heartbeat_timeout_monitor_core_assert.svh -----
// ----------------------------------------------------------------------------
// Heartbeat monitor assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_TIMEOUT_MONITOR_CORE_ASSERT_SVH
`define HEARTBEAT_TIMEOUT_MONITOR_CORE_ASSERT_SVH

// same-cycle implication
`define HBTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heartbeat monitor check failed");

// next-cycle implication
`define HBTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heartbeat monitor check failed");

`endif

// ----- src/hbtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Shared types, request/result payloads and constants.
// ----------------------------------------------------------------------------
package hbtm_pkg;

  localparam int unsigned ID_BITS_DEF    = 8;
  localparam int unsigned STAMP_BITS_DEF = 32;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MISS_W  = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  localparam logic [15:0] INTERVAL_RST   = 16'd5;
  localparam logic [15:0] TIMEOUT_RST    = 16'd10;
  localparam logic [7:0]  MAX_MISSES_RST = 8'd3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESP  = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } hbtm_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL   = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_MAX_MISSES = 2'd2
  } hbtm_cfg_idx_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] response_id;
  } hbtm_req_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_id;
    logic              disconnect;
    logic [MISS_W-1:0] miss_count;
    logic              running;
  } hbtm_rsp_t;

  typedef struct packed {
    logic [15:0] interval_ticks;
    logic [15:0] timeout_ticks;
    logic [7:0]  max_misses;
  } hbtm_cfg_t;

endpackage

// ----- src/hbtm_table.sv -----
// ----------------------------------------------------------------------------
// Heartbeat monitor pending table
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hbtm_table #(
  parameter int unsigned ADDR_BITS = hbtm_pkg::ID_BITS_DEF,
  parameter int unsigned DATA_BITS = hbtm_pkg::STAMP_BITS_DEF + 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/hbtm_engine.sv -----
// ----------------------------------------------------------------------------
// Heartbeat monitor engine
// Request sequencer: send decision, pipelined table scan, response clear.
// ----------------------------------------------------------------------------
module hbtm_engine #(
  parameter int unsigned ID_BITS    = hbtm_pkg::ID_BITS_DEF,
  parameter int unsigned STAMP_BITS = hbtm_pkg::STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  hbtm_pkg::hbtm_req_t   req_i,
  input  hbtm_pkg::hbtm_cfg_t   cfg_i,
  output logic                  rsp_valid_o,
  output hbtm_pkg::hbtm_rsp_t   rsp_o,
  output logic                  mem_we_o,
  output logic [ID_BITS-1:0]    mem_waddr_o,
  output logic [STAMP_BITS:0]   mem_wdata_o,
  output logic                  mem_re_o,
  output logic [ID_BITS-1:0]    mem_raddr_o,
  input  logic [STAMP_BITS:0]   mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_SCAN,
    ST_TICK_END
  } state_e;

  state_e                        state_q;
  logic [ID_BITS-1:0]            clr_q;
  logic                          active_q;
  logic [hbtm_pkg::CNT_W-1:0]    icnt_q;
  logic [hbtm_pkg::CNT_W-1:0]    ccnt_q;
  logic [STAMP_BITS-1:0]         now_q;
  logic [ID_BITS-1:0]            nid_q;
  logic [hbtm_pkg::MISS_W-1:0]   missed_q;
  logic                          sv_q;
  logic [7:0]                    sid_q;
  logic                          disc_q;
  logic                          rvld_q;
  logic [ID_BITS-1:0]            rid_q;
  logic [ID_BITS:0]              scan_q;
  logic                          ev_vld_q;
  logic [ID_BITS-1:0]            ev_addr_q;

  logic                          accept;
  logic [ID_BITS-1:0]            rid;
  logic                          send_now;
  logic                          check_now;
  logic                          ent_valid;
  logic [STAMP_BITS-1:0]         ent_stamp;
  logic [STAMP_BITS-1:0]         age;
  logic                          expired;
  logic [hbtm_pkg::MISS_W-1:0]   miss_next;
  logic                          limit_hit;
  logic                          scan_done;
  logic                          issue;

  always_comb begin
    accept    = start && (state_q == ST_IDLE);
    rid       = ID_BITS'(req_i.response_id);
    send_now  = active_q && (icnt_q >= cfg_i.interval_ticks);
    check_now = active_q && (ccnt_q >= cfg_i.timeout_ticks);
    ent_valid = mem_rdata_i[STAMP_BITS];
    ent_stamp = mem_rdata_i[STAMP_BITS-1:0];
    age       = now_q - ent_stamp;
    expired   = ev_vld_q && ent_valid && (age > STAMP_BITS'(cfg_i.timeout_ticks));
    miss_next = (expired && (missed_q != hbtm_pkg::MISS_MAX)) ? missed_q + 1'b1 : missed_q;
    // limit is tested after every pending entry visited, expired or not
    limit_hit = ev_vld_q && ent_valid &&
                (miss_next > hbtm_pkg::MISS_W'(cfg_i.max_misses));
    scan_done = scan_q[ID_BITS];
    issue     = (state_q == ST_SCAN) && !limit_hit && !scan_done;
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
      end
      ST_IDLE: begin
        if (accept && (req_i.kind == hbtm_pkg::KIND_TICK) && send_now) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = nid_q;
          mem_wdata_o = {1'b1, now_q};
        end
        if (accept && (req_i.kind == hbtm_pkg::KIND_RESP)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rid;
        end
      end
      ST_RESP: begin
        if (ent_valid) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = rid_q;
        end
      end
      ST_SCAN: begin
        // write-back goes to the entry in evaluation, read to the next one
        if (expired) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ev_addr_q;
        end
        if (issue) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_q[ID_BITS-1:0];
        end
      end
      ST_TICK_END: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      active_q  <= 1'b0;
      icnt_q    <= '0;
      ccnt_q    <= '0;
      now_q     <= '0;
      nid_q     <= '0;
      missed_q  <= '0;
      sv_q      <= 1'b0;
      sid_q     <= '0;
      disc_q    <= 1'b0;
      rvld_q    <= 1'b0;
      rid_q     <= '0;
      scan_q    <= '0;
      ev_vld_q  <= 1'b0;
      ev_addr_q <= '0;
    end else begin
      rvld_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            sv_q   <= 1'b0;
            sid_q  <= '0;
            disc_q <= 1'b0;
            unique case (req_i.kind)
              hbtm_pkg::KIND_TICK: begin
                if (send_now) begin
                  sv_q   <= 1'b1;
                  sid_q  <= 8'(nid_q);
                  nid_q  <= nid_q + 1'b1;
                  icnt_q <= '0;
                end
                if (check_now) begin
                  ccnt_q   <= '0;
                  scan_q   <= '0;
                  ev_vld_q <= 1'b0;
                  state_q  <= ST_SCAN;
                end else begin
                  state_q  <= ST_TICK_END;
                end
              end
              hbtm_pkg::KIND_RESP: begin
                rid_q   <= rid;
                state_q <= ST_RESP;
              end
              hbtm_pkg::KIND_START: begin
                active_q <= 1'b1;
                icnt_q   <= '0;
                ccnt_q   <= '0;
                rvld_q   <= 1'b1;
              end
              hbtm_pkg::KIND_STOP: begin
                active_q <= 1'b0;
                rvld_q   <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RESP: begin
          if (ent_valid) begin
            missed_q <= '0;
          end
          rvld_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          if (ev_vld_q) begin
            missed_q <= miss_next;
          end
          if (limit_hit) begin
            // drop the read in flight and disconnect
            disc_q   <= 1'b1;
            active_q <= 1'b0;
            ev_vld_q <= 1'b0;
            state_q  <= ST_TICK_END;
          end else if (issue) begin
            ev_vld_q  <= 1'b1;
            ev_addr_q <= scan_q[ID_BITS-1:0];
            scan_q    <= scan_q + 1'b1;
          end else begin
            ev_vld_q <= 1'b0;
            if (!ev_vld_q && scan_done) begin
              state_q <= ST_TICK_END;
            end
          end
        end
        ST_TICK_END: begin
          if (active_q) begin
            icnt_q <= (icnt_q == hbtm_pkg::CNT_MAX) ? icnt_q : icnt_q + 1'b1;
            ccnt_q <= (ccnt_q == hbtm_pkg::CNT_MAX) ? ccnt_q : ccnt_q + 1'b1;
          end
          now_q   <= now_q + 1'b1;
          rvld_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rvld_q;

  always_comb begin
    rsp_o.send_valid = sv_q;
    rsp_o.send_id    = sid_q;
    rsp_o.disconnect = disc_q;
    rsp_o.miss_count = missed_q;
    rsp_o.running    = active_q;
  end

endmodule

// ----- src/heartbeat_timeout_monitor_core.sv -----
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor core
// Keepalive monitor: heartbeat send, pending table scan and disconnect.
// ----------------------------------------------------------------------------
// Usage:
//   A request (tick, response, start or stop) is taken on a rising edge with
//   start high and busy low. Each request gives exactly one result on rsp_o,
//   marked by rsp_valid_o for one cycle; the receiver cannot hold it off.
//   A start or stop gives its result in the next cycle; a response passes
//   through the table read and ST_RESP; a tick through ST_TICK_END, after
//   ST_SCAN if a check is due, the scan through the pending table, one entry per
//   cycle on the single RAM read port. busy stays high until the result
//   is out; a new request may be taken in the result cycle.
//   After reset the block clears the whole pending table with busy high;
//   configuration writes are taken throughout. Config registers are written
//   through cfg_we_i / cfg_index_i / cfg_wdata_i, no read-back. The user must
//   write them only while no request is in flight; the block does not check.
// ----------------------------------------------------------------------------
module heartbeat_timeout_monitor_core #(
  parameter int unsigned ID_BITS    = hbtm_pkg::ID_BITS_DEF,
  parameter int unsigned STAMP_BITS = hbtm_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  hbtm_pkg::hbtm_req_t             req_i,
  output logic                            rsp_valid_o,
  output hbtm_pkg::hbtm_rsp_t             rsp_o,
  input  logic                            cfg_we_i,
  input  logic [hbtm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hbtm_pkg::CFG_W-1:0]      cfg_wdata_i
);

  hbtm_pkg::hbtm_cfg_t   cfg_q;

  logic                  mem_we;
  logic [ID_BITS-1:0]    mem_waddr;
  logic [STAMP_BITS:0]   mem_wdata;
  logic                  mem_re;
  logic [ID_BITS-1:0]    mem_raddr;
  logic [STAMP_BITS:0]   mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ticks <= hbtm_pkg::INTERVAL_RST;
      cfg_q.timeout_ticks  <= hbtm_pkg::TIMEOUT_RST;
      cfg_q.max_misses     <= hbtm_pkg::MAX_MISSES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hbtm_pkg::CFG_INTERVAL:   cfg_q.interval_ticks <= cfg_wdata_i;
        hbtm_pkg::CFG_TIMEOUT:    cfg_q.timeout_ticks  <= cfg_wdata_i;
        hbtm_pkg::CFG_MAX_MISSES: cfg_q.max_misses     <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  hbtm_engine #(
    .ID_BITS    (ID_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  hbtm_table #(
    .ADDR_BITS (ID_BITS),
    .DATA_BITS (STAMP_BITS + 1)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- src/hbtm_checker.sv -----
// ----------------------------------------------------------------------------
// Heartbeat monitor port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`include "heartbeat_timeout_monitor_core_assert.svh"

module hbtm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input hbtm_pkg::hbtm_req_t  req_i,
  input logic                 rsp_valid_o,
  input hbtm_pkg::hbtm_rsp_t  rsp_o
);

  // stop answers in the next cycle with the monitor halted
  `HBTM_ASSERT_NEXT(a_stop_result, start && !busy && (req_i.kind == hbtm_pkg::KIND_STOP), rsp_valid_o && !rsp_o.running)

  // start answers in the next cycle, running, nothing sent
  `HBTM_ASSERT_NEXT(a_start_result, start && !busy && (req_i.kind == hbtm_pkg::KIND_START), rsp_valid_o && rsp_o.running && !rsp_o.send_valid && !rsp_o.disconnect)

  // a disconnect always leaves the monitor stopped
  `HBTM_ASSERT_IMP(a_disc_stops, rsp_valid_o && rsp_o.disconnect, !rsp_o.running)

  // no heartbeat, no id
  `HBTM_ASSERT_IMP(a_idle_id_zero, rsp_valid_o && !rsp_o.send_valid, rsp_o.send_id == 8'd0)

endmodule

bind heartbeat_timeout_monitor_core hbtm_checker u_hbtm_checker (.*);
